/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the frame parser rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define BFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bfp_pkg.sv */
// ---------------------------------------------------------------------------
// bfp_pkg
// shared constants, controller states and control structs of the frame parser
// ---------------------------------------------------------------------------
package bfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int IDX_W       = 6;
    localparam int SUM_W       = 16;

    localparam logic [BYTE_W-1:0] BYTE_START = 8'hDD;
    localparam logic [BYTE_W-1:0] BYTE_READ  = 8'hA5;
    localparam logic [BYTE_W-1:0] BYTE_WRITE = 8'h5A;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h77;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_MARK,
        ST_REG,
        ST_LEN,
        ST_DATA,
        ST_CKHI,
        ST_CKLO,
        ST_END,
        ST_RD,
        ST_LOAD,
        ST_SHOW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic set_mark;
        logic load_reg;
        logic load_len;
        logic store_data;
        logic load_ckhi;
        logic eval_ck;
        logic drain_start;
        logic rd_issue;
        logic out_load;
        logic drain_next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_mark;
        logic is_end;
        logic len_over;
        logic len_zero;
        logic data_done;
        logic ck_good;
        logic drain_last;
    } t_stat;

endpackage

/* rtl/bfp_ram.sv */
// ---------------------------------------------------------------------------
// bfp_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module bfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bfp_ctrl.sv */
// ---------------------------------------------------------------------------
// bfp_ctrl
// frame phase sequencer and payload drain controller
// ---------------------------------------------------------------------------
module bfp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  bfp_pkg::t_stat i_stat,
    output bfp_pkg::t_cmd  o_cmd
);
    import bfp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   acc;
    t_state abort_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state == ST_RD) || (r_state == ST_LOAD) || (r_state == ST_SHOW);
    assign o_out_valid = (r_state == ST_SHOW);
    assign acc         = i_in_valid && !o_in_stall;
    assign abort_st    = i_stat.is_start ? ST_MARK : ST_HUNT;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_HUNT: begin
                if (acc && i_stat.is_start) n_state = ST_MARK;
            end
            ST_MARK: begin
                if (acc) begin
                    if (i_stat.is_mark) begin
                        o_cmd.set_mark = 1'b1;
                        n_state        = ST_REG;
                    end else begin
                        n_state = abort_st;
                    end
                end
            end
            ST_REG: begin
                if (acc) begin
                    o_cmd.load_reg = 1'b1;
                    n_state        = ST_LEN;
                end
            end
            ST_LEN: begin
                if (acc) begin
                    if (i_stat.len_over) begin
                        n_state = abort_st;
                    end else begin
                        o_cmd.load_len = 1'b1;
                        n_state        = i_stat.len_zero ? ST_CKHI : ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (acc) begin
                    o_cmd.store_data = 1'b1;
                    if (i_stat.data_done) n_state = ST_CKHI;
                end
            end
            ST_CKHI: begin
                if (acc) begin
                    o_cmd.load_ckhi = 1'b1;
                    n_state         = ST_CKLO;
                end
            end
            ST_CKLO: begin
                if (acc) begin
                    o_cmd.eval_ck = 1'b1;
                    n_state       = ST_END;
                end
            end
            ST_END: begin
                if (acc) begin
                    if (i_stat.is_end && i_stat.ck_good) begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = ST_RD;
                    end else begin
                        n_state = abort_st;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_SHOW;
            end
            ST_SHOW: begin
                if (!i_out_stall) begin
                    if (i_stat.drain_last) begin
                        n_state = ST_HUNT;
                    end else begin
                        o_cmd.drain_next = 1'b1;
                        n_state          = ST_RD;
                    end
                end
            end
            default: n_state = ST_HUNT;
        endcase
    end

endmodule

/* rtl/bfp_dpath.sv */
// ---------------------------------------------------------------------------
// bfp_dpath
// frame header registers, running checksum, payload buffer and result word
// ---------------------------------------------------------------------------
module bfp_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [bfp_pkg::BYTE_W-1:0]   i_rx_byte,
    input  bfp_pkg::t_cmd                i_cmd,
    output bfp_pkg::t_stat               o_stat,
    output logic                         o_frame_is_write,
    output logic [bfp_pkg::BYTE_W-1:0]   o_register_number,
    output logic [bfp_pkg::LEN_W-1:0]    o_frame_length,
    output logic                         o_has_data,
    output logic [bfp_pkg::IDX_W-1:0]    o_byte_index,
    output logic [bfp_pkg::BYTE_W-1:0]   o_data_value,
    output logic                         o_last_of_frame
);
    import bfp_pkg::*;

    logic              r_write;
    logic [BYTE_W-1:0] r_reg;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_ckhi;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ck_good;
    logic [IDX_W-1:0]  r_idx;

    logic              r_o_write;
    logic [BYTE_W-1:0] r_o_reg;
    logic [LEN_W-1:0]  r_o_len;
    logic              r_o_has;
    logic [IDX_W-1:0]  r_o_idx;
    logic [BYTE_W-1:0] r_o_data;
    logic              r_o_last;

    logic [BYTE_W-1:0] ram_q;
    logic [LEN_W-1:0]  cnt_inc;
    logic [SUM_W-1:0]  sum_add;
    logic [SUM_W-1:0]  sum_neg;
    logic              has_pay;

    assign cnt_inc = r_cnt + LEN_W'(1);
    assign sum_add = r_sum + SUM_W'(i_rx_byte);
    assign sum_neg = SUM_W'(0) - r_sum;
    assign has_pay = (r_len != '0);

    assign o_stat.is_start   = (i_rx_byte == BYTE_START);
    assign o_stat.is_mark    = (i_rx_byte == BYTE_READ) || (i_rx_byte == BYTE_WRITE);
    assign o_stat.is_end     = (i_rx_byte == BYTE_END);
    assign o_stat.len_over   = (i_rx_byte > BYTE_W'(MAX_PAYLOAD));
    assign o_stat.len_zero   = (i_rx_byte == '0);
    assign o_stat.data_done  = (cnt_inc >= r_len);
    assign o_stat.ck_good    = r_ck_good;
    assign o_stat.drain_last = !has_pay || ((LEN_W'(r_idx) + LEN_W'(1)) == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write   <= 1'b0;
            r_reg     <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_ckhi    <= '0;
            r_sum     <= '0;
            r_ck_good <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.set_mark)   r_write <= (i_rx_byte == BYTE_WRITE);
            if (i_cmd.load_reg) begin
                r_reg <= i_rx_byte;
                r_sum <= SUM_W'(i_rx_byte);
            end
            if (i_cmd.load_len) begin
                r_len <= LEN_W'(i_rx_byte);
                r_cnt <= '0;
                r_sum <= sum_add;
            end
            if (i_cmd.store_data) begin
                r_cnt <= cnt_inc;
                r_sum <= sum_add;
            end
            if (i_cmd.load_ckhi)  r_ckhi <= i_rx_byte;
            if (i_cmd.eval_ck)    r_ck_good <= (sum_neg == {r_ckhi, i_rx_byte});
            if (i_cmd.drain_start) r_idx <= '0;
            if (i_cmd.drain_next)  r_idx <= r_idx + IDX_W'(1);
        end
    end

    bfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_data),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    // result word, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_write <= r_write;
            r_o_reg   <= r_reg;
            r_o_len   <= r_len;
            r_o_has   <= has_pay;
            r_o_idx   <= has_pay ? r_idx : '0;
            r_o_data  <= has_pay ? ram_q : '0;
            r_o_last  <= o_stat.drain_last;
        end
    end

    assign o_frame_is_write  = r_o_write;
    assign o_register_number = r_o_reg;
    assign o_frame_length    = r_o_len;
    assign o_has_data        = r_o_has;
    assign o_byte_index      = r_o_idx;
    assign o_data_value      = r_o_data;
    assign o_last_of_frame   = r_o_last;

endmodule

/* rtl/bms_frame_parser.sv */
// ---------------------------------------------------------------------------
// bms_frame_parser
// byte-serial frame parser for a battery-management link, additive checksum
// ---------------------------------------------------------------------------
// usage
// - input channel: one received byte per word on i_rx_byte, taken at an edge
//   with i_in_valid high and o_in_stall low
// - frame: DD, A5 (read) or 5A (write), register, length (0..64), data bytes,
//   checksum high, checksum low, 77; checksum is the 16-bit negated sum of
//   register, length and data
// - a bad marker, overlong length, bad end byte or checksum mismatch drops the
//   frame; a DD in those places restarts it, anything else goes back to hunting
// - output channel: one word per payload byte (one header-only word for an
//   empty frame), taken at an edge with o_out_valid high and i_out_stall low;
//   o_last_of_frame marks the final word
// - drain: after the end byte the payload buffer drains word by word through
//   read, load and show states, limited by the single registered read port
//   of the buffer; the next word is read only once the shown one is taken
// - first result word is valid in the show state, after read and load
// - while words drain o_in_stall is high; a stalled output word holds, and the
//   drain waits on it
// - reset (synchronous, active low) returns to hunting for DD with nothing
//   pending; the payload buffer is not cleared
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bms_frame_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bfp_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_frame_is_write,
    output logic [bfp_pkg::BYTE_W-1:0]   o_register_number,
    output logic [bfp_pkg::LEN_W-1:0]    o_frame_length,
    output logic                         o_has_data,
    output logic [bfp_pkg::IDX_W-1:0]    o_byte_index,
    output logic [bfp_pkg::BYTE_W-1:0]   o_data_value,
    output logic                         o_last_of_frame
);
    import bfp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // phase sequencer and drain control
    bfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // header, checksum, payload buffer and result word
    bfp_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_frame_is_write  (o_frame_is_write),
        .o_register_number (o_register_number),
        .o_frame_length    (o_frame_length),
        .o_has_data        (o_has_data),
        .o_byte_index      (o_byte_index),
        .o_data_value      (o_data_value),
        .o_last_of_frame   (o_last_of_frame)
    );

    // input is never taken while a result word is pending
    `BFP_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_out_valid && !o_in_stall), "input open while draining")

    // a payload word always lies inside the frame length
    `BFP_ASSERT(a_idx_range, i_clk, i_rst_n, (o_out_valid && o_has_data) |-> (7'(o_byte_index) < o_frame_length), "byte index beyond length")

    // an empty frame gives exactly one word
    `BFP_ASSERT(a_empty_last, i_clk, i_rst_n, (o_out_valid && !o_has_data) |-> o_last_of_frame, "empty frame word not last")

    // once the last word is taken, input opens again
    `BFP_ASSERT(a_reopen, i_clk, i_rst_n, (o_out_valid && !i_out_stall && o_last_of_frame) |=> !o_in_stall, "input stays closed after frame")

endmodule
